FILE: sv/plst_pkg.sv
// Shared types and constants for the positional list store.
// No dependencies; imported by plst_cell and positional_list_store.
package plst_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;
  localparam int DISP_MAX    = (MAX_RESULTS < CAPACITY) ? MAX_RESULTS : CAPACITY;

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = ((LEN_W > 8) ? LEN_W : 8) + 1;

  localparam int VAL_W = 32;
  localparam int SUM_W = 36;
  localparam int CNT_W = 5;

  typedef enum logic [2:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DISPLAY   = 3'd6,
    OP_COUNT     = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_LOAD,
    CM_FROM_LEFT,
    CM_FROM_RIGHT
  } cell_mode_t;

  // per-cell control from the sequencer
  typedef struct packed {
    cell_mode_t mode;
    logic       valid;   // cell lies below the list length
  } cell_ctrl_t;

  // running summary handed along the chain
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic signed [VAL_W-1:0] mn;
    logic signed [VAL_W-1:0] mx;
    logic                    any;
  } summary_t;

endpackage

FILE: sv/plst_cell.sv
// One cell of the list chain: holds one entry and folds it into the running summary.
// Depends on plst_pkg.
module plst_cell
  import plst_pkg::*;
(
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic signed [VAL_W-1:0] value,
  input  logic signed [VAL_W-1:0] left,
  input  logic signed [VAL_W-1:0] right,
  input  summary_t                part_in,
  output logic signed [VAL_W-1:0] entry,
  output summary_t                part_out
);

  summary_t part_next;

  always_comb begin
    part_next = part_in;
    if (ctrl.valid) begin
      part_next.sum = part_in.sum + SUM_W'(entry);
      part_next.mn  = (!part_in.any || entry < part_in.mn) ? entry : part_in.mn;
      part_next.mx  = (!part_in.any || entry > part_in.mx) ? entry : part_in.mx;
      part_next.any = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      CM_LOAD:       entry <= value;
      CM_FROM_LEFT:  entry <= left;
      CM_FROM_RIGHT: entry <= right;
      default:       entry <= entry;
    endcase
    part_out <= part_next;
  end

endmodule

FILE: sv/positional_list_store.sv
// Positional list store: ordered list of signed words held in a chain of cells.
// Operation: a request is taken while idle, then the summary ripples through the
// registered chain of cells in the settle state before the result words are offered.
// A new request is taken only after the final result word has been taken.
// Reset: synchronous, clears the length and the sequencer; entries stay undefined.
// Depends on plst_pkg and plst_cell.
module positional_list_store
  import plst_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              op,
  input  logic signed [VAL_W-1:0] value,
  input  logic [7:0]              position,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic signed [VAL_W-1:0] element,
  output logic                    last,
  output logic [CNT_W-1:0]        count,
  output logic signed [SUM_W-1:0] total,
  output logic signed [VAL_W-1:0] smallest,
  output logic signed [VAL_W-1:0] largest
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETTLE,
    S_EMIT
  } state_t;

  state_t           state;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] len_next;
  logic [LEN_W-1:0] cnt;
  logic [LEN_W-1:0] disp_last;
  logic             disp;
  status_t          st_reg;
  status_t          st_next;

  logic             ins_ok;
  logic             del_ok;
  logic [LEN_W-1:0] idx;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] len_ext;
  logic             take;

  logic signed [VAL_W-1:0] entries [CAPACITY];
  summary_t                parts   [CAPACITY+1];
  cell_ctrl_t              ctrls   [CAPACITY];

  assign take    = in_valid && in_ready;
  assign pos_ext = CMP_W'(position);
  assign len_ext = CMP_W'(len);

  // decode the request against the current length
  always_comb begin
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    idx      = '0;
    st_next  = ST_OK;
    len_next = len;
    case (op_t'(op))
      OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
        if (len == LEN_W'(CAPACITY)) begin
          st_next = ST_FULL;
        end else if (op_t'(op) == OP_INS_FIRST) begin
          ins_ok = 1'b1;
        end else if (op_t'(op) == OP_INS_LAST) begin
          ins_ok = 1'b1;
          idx    = len;
        end else if (pos_ext == '0 || pos_ext > len_ext + CMP_W'(1)) begin
          st_next = ST_BADPOS;
        end else begin
          ins_ok = 1'b1;
          idx    = LEN_W'(pos_ext - CMP_W'(1));
        end
        if (ins_ok) len_next = len + LEN_W'(1);
      end
      OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
        if (len == '0) begin
          st_next = ST_EMPTY;
        end else if (op_t'(op) == OP_DEL_FIRST) begin
          del_ok = 1'b1;
        end else if (op_t'(op) == OP_DEL_LAST) begin
          del_ok = 1'b1;
          idx    = len - LEN_W'(1);
        end else if (pos_ext == '0 || pos_ext > len_ext) begin
          st_next = ST_BADPOS;
        end else begin
          del_ok = 1'b1;
          idx    = LEN_W'(pos_ext - CMP_W'(1));
        end
        if (del_ok) len_next = len - LEN_W'(1);
      end
      OP_DISPLAY: begin
        if (len == '0) st_next = ST_EMPTY;
      end
      default: begin
        st_next = ST_OK;
      end
    endcase
  end

  assign parts[0] = '{sum: '0, mn: '0, mx: '0, any: 1'b0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_w;
    logic signed [VAL_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = value;
    end else begin : g_mid
      assign left_w = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_w = entries[i];
    end else begin : g_inner
      assign right_w = entries[i+1];
    end

    always_comb begin
      ctrls[i].valid = (LEN_W'(i) < len);
      ctrls[i].mode  = CM_HOLD;
      if (take && ins_ok) begin
        if (LEN_W'(i) == idx) begin
          ctrls[i].mode = CM_LOAD;
        end else if (LEN_W'(i) > idx) begin
          ctrls[i].mode = CM_FROM_LEFT;
        end
      end else if (take && del_ok && i != CAPACITY - 1) begin
        if (LEN_W'(i) >= idx) ctrls[i].mode = CM_FROM_RIGHT;
      end
    end

    plst_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrls[i]),
      .value    (value),
      .left     (left_w),
      .right    (right_w),
      .part_in  (parts[i]),
      .entry    (entries[i]),
      .part_out (parts[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      cnt       <= '0;
      disp      <= 1'b0;
      disp_last <= '0;
      st_reg    <= ST_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            len       <= len_next;
            st_reg    <= st_next;
            disp      <= (op_t'(op) == OP_DISPLAY) && (len != '0);
            disp_last <= ((len > LEN_W'(DISP_MAX)) ? LEN_W'(DISP_MAX) : len) - LEN_W'(1);
            cnt       <= '0;
            state     <= S_SETTLE;
          end
        end
        S_SETTLE: begin
          // wait for the summary to reach the end of the chain
          if (cnt == LEN_W'(CAPACITY - 1)) begin
            cnt   <= '0;
            state <= S_EMIT;
          end else begin
            cnt <= cnt + LEN_W'(1);
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if (last) begin
              state <= S_IDLE;
            end else begin
              cnt <= cnt + LEN_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign status    = st_reg;
  assign element   = disp ? entries[cnt[IDX_W-1:0]] : '0;
  assign last      = !disp || (cnt == disp_last);
  assign count     = CNT_W'(len);
  assign total     = parts[CAPACITY].sum;
  assign smallest  = parts[CAPACITY].any ? parts[CAPACITY].mn : '0;
  assign largest   = parts[CAPACITY].any ? parts[CAPACITY].mx : '0;

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input taken while a result word is pending");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(CAPACITY))
    else $error("list length beyond capacity");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    take |=> !in_ready && !out_valid)
    else $error("summary not given time to settle");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> in_ready)
    else $error("sequencer did not return to idle after final word");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (count == '0 && total == '0))
    else $error("empty status with non-empty summary");

endmodule
